// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion wrappers for the snapshot RLE decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/srle_pkg.sv
// ----------------------------------------------------------------------------
// srle_pkg
// Types and constants shared by the snapshot RLE block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srle_pkg;

  localparam logic [7:0] RUN_MARK  = 8'hED;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // records one input word can produce, also the depth of the record buffer
  localparam int REC_SLOTS = 3;

  // register index carried on paddr[2]
  localparam logic CFG_IDX_END_MODE = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ED1,
    PH_ED2,
    PH_CNT,
    PH_Z0,
    PH_Z0E,
    PH_Z0EE
  } phase_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic [7:0]  count;
    logic        done;
    logic        trunc;
    logic        last;
  } rec_t;

endpackage

// File: hw/rtl/snapshot_rle_block_decoder.sv
// ----------------------------------------------------------------------------
// snapshot_rle_block_decoder
// Compressed snapshot memory block decoder producing fill records.
// ----------------------------------------------------------------------------
// Input channel (data_valid / data_stall) carries one compressed byte per word
// with start_block, start_address and end_of_block. Output channel
// (fill_valid / fill_stall) carries fill records: write fill_value to
// fill_count addresses from fill_address; block_done, truncated and
// last_result flag the block end and the final record of an input word.
// end_mode is written over the APB port when paddr[2] is 0; the user must
// write it only while the block is idle, the block does not enforce this.
// An accepted word waits in the input register, is decoded from there and its
// records are registered into the record buffer. Throughput is one byte per
// cycle while each byte gives at most one record and fill_stall is low; the
// single output port moves one record per cycle. A three-entry record buffer
// after the decoder holds records while fill_stall is high; data_stall
// rises only when that buffer lacks room for the waiting byte's records.
// Reset clears the buffers, sets end_mode to 0 and leaves no block open.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module snapshot_rle_block_decoder (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // compressed bytes
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_block,
  input  logic [15:0] start_address,
  input  logic        end_of_block,
  // fill records
  output logic        fill_valid,
  input  logic        fill_stall,
  output logic [15:0] fill_address,
  output logic [7:0]  fill_value,
  output logic [7:0]  fill_count,
  output logic        block_done,
  output logic        truncated,
  output logic        last_result
);
  import srle_pkg::*;

  logic                 end_mode;
  logic                 cfg_write;

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_start;
  logic [15:0]          s1_address;
  logic                 s1_end;
  logic                 in_take;

  logic [1:0]           dec_cnt;
  rec_t [REC_SLOTS-1:0] dec_recs;
  logic                 consume;

  rec_t                 rbuf [REC_SLOTS];
  rec_t                 rbuf_next [REC_SLOTS];
  rec_t                 shifted [REC_SLOTS];
  logic [1:0]           buf_cnt;
  logic [1:0]           buf_cnt_next;
  logic                 pop;
  logic [1:0]           n_ap;
  logic [1:0]           slot_idx;

  // --- configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_END_MODE);
  assign prdata    = (paddr[2] == CFG_IDX_END_MODE) ? {31'd0, end_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_mode <= 1'b0;
    end else if (cfg_write) begin
      end_mode <= pwdata[0];
    end
  end

  // --- input register
  assign data_stall = s1_valid && !consume;
  assign in_take    = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte    <= data_byte;
      s1_start   <= start_block;
      s1_address <= start_address;
      s1_end     <= end_of_block;
    end
  end

  srle_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .end_mode      (end_mode),
    .fire          (consume),
    .data_byte     (s1_byte),
    .start_block   (s1_start),
    .start_address (s1_address),
    .end_of_block  (s1_end),
    .rec_cnt       (dec_cnt),
    .recs          (dec_recs)
  );

  // --- record buffer: slot 0 is the output register
  assign pop     = (buf_cnt != 2'd0) && !fill_stall;
  assign n_ap    = buf_cnt - {1'b0, pop};
  assign consume = s1_valid && (({1'b0, n_ap} + {1'b0, dec_cnt}) <= 3'(REC_SLOTS));

  always_comb begin
    slot_idx = 2'd0;
    for (int i = 0; i < REC_SLOTS; i++) begin
      if (pop && i < REC_SLOTS - 1) begin
        shifted[i] = rbuf[i + 1];
      end else begin
        shifted[i] = rbuf[i];
      end
    end
    for (int i = 0; i < REC_SLOTS; i++) begin
      slot_idx     = 2'(i) - n_ap;
      rbuf_next[i] = shifted[i];
      // append new records behind whatever stays
      if (consume && 2'(i) >= n_ap && slot_idx < dec_cnt) begin
        rbuf_next[i] = dec_recs[slot_idx];
      end
    end
    buf_cnt_next = consume ? (n_ap + dec_cnt) : n_ap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else begin
      buf_cnt <= buf_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < REC_SLOTS; i++) begin
      rbuf[i] <= rbuf_next[i];
    end
  end

  assign fill_valid   = (buf_cnt != 2'd0);
  assign fill_address = rbuf[0].addr;
  assign fill_value   = rbuf[0].value;
  assign fill_count   = rbuf[0].count;
  assign block_done   = rbuf[0].done;
  assign truncated    = rbuf[0].trunc;
  assign last_result  = rbuf[0].last;

  `ASSERT_NEVER(a_stall_empty, clk, rst, !s1_valid && data_stall)
  `ASSERT_CLK(a_full_hold, clk, rst, buf_cnt == 2'd3 && fill_stall |=> buf_cnt == 2'd3)
  `ASSERT_CLK(a_load, clk, rst, in_take |=> s1_valid)

endmodule

// File: hw/rtl/srle_decode.sv
// ----------------------------------------------------------------------------
// srle_decode
// Decode phase machine: turns one compressed byte into up to three records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srle_decode (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       end_mode,
  input  logic                                       fire,
  input  logic [7:0]                                 data_byte,
  input  logic                                       start_block,
  input  logic [15:0]                                start_address,
  input  logic                                       end_of_block,
  output logic [1:0]                                 rec_cnt,
  output srle_pkg::rec_t [srle_pkg::REC_SLOTS-1:0]  recs
);
  import srle_pkg::*;

  typedef struct packed {
    rec_t [REC_SLOTS-1:0] recs;
    logic [1:0]           cnt;
    logic [15:0]          wa;
  } rlist_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [15:0] write_address;
  logic [7:0]  run_length;
  logic [7:0]  run_length_next;
  logic        block_finished;
  logic        block_finished_next;
  rlist_t      lst;
  logic        active;
  logic        do_lit;
  logic        done_any;

  // append one record at the running address, drop it if the list is full
  function automatic rlist_t push_rec(rlist_t l, logic [7:0] v, logic [7:0] c,
                                      logic d, logic t);
    rlist_t o;
    o = l;
    if (l.cnt != 2'd3) begin
      o.recs[l.cnt] = '{addr: l.wa, value: v, count: c, done: d, trunc: t,
                        last: 1'b0};
      o.cnt = l.cnt + 2'd1;
      o.wa  = l.wa + {8'd0, c};
    end
    return o;
  endfunction

  always_comb begin
    lst                 = '0;
    lst.wa              = write_address;
    phase_next          = phase;
    run_length_next     = run_length;
    block_finished_next = block_finished;
    active              = 1'b1;
    do_lit              = 1'b0;

    if (start_block) begin
      lst.wa              = start_address;
      phase_next          = PH_IDLE;
      run_length_next     = 8'd0;
      block_finished_next = 1'b0;
    end else if (block_finished) begin
      active = 1'b0;
    end

    if (active) begin
      unique case (phase_next)
        PH_ED1: begin
          if (data_byte == RUN_MARK) begin
            phase_next = PH_ED2;
          end else begin
            lst    = push_rec(lst, RUN_MARK, 8'd1, 1'b0, 1'b0);
            do_lit = 1'b1;
          end
        end
        PH_ED2: begin
          run_length_next = data_byte;
          phase_next      = PH_CNT;
        end
        PH_CNT: begin
          if (run_length_next != 8'd0) begin
            lst = push_rec(lst, data_byte, run_length_next, 1'b0, 1'b0);
          end
          phase_next = PH_IDLE;
        end
        PH_Z0: begin
          if (data_byte == RUN_MARK) begin
            phase_next = PH_Z0E;
          end else begin
            lst    = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            do_lit = 1'b1;
          end
        end
        PH_Z0E: begin
          if (data_byte == RUN_MARK) begin
            phase_next = PH_Z0EE;
          end else begin
            lst    = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            lst    = push_rec(lst, RUN_MARK, 8'd1, 1'b0, 1'b0);
            do_lit = 1'b1;
          end
        end
        PH_Z0EE: begin
          if (data_byte == ZERO_BYTE) begin
            // terminator seen: close the block with a pure end record
            phase_next          = PH_IDLE;
            block_finished_next = 1'b1;
            lst                 = push_rec(lst, 8'd0, 8'd0, 1'b1, 1'b0);
          end else begin
            lst             = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            run_length_next = data_byte;
            phase_next      = PH_CNT;
          end
        end
        default: begin
          do_lit = 1'b1;
        end
      endcase

      if (do_lit) begin
        if (data_byte == RUN_MARK) begin
          phase_next = PH_ED1;
        end else if (end_mode && data_byte == ZERO_BYTE) begin
          phase_next = PH_Z0;
        end else begin
          phase_next = PH_IDLE;
          lst        = push_rec(lst, data_byte, 8'd1, 1'b0, 1'b0);
        end
      end

      if (!block_finished_next && !end_mode && end_of_block) begin
        // at block end, flush a pending zero of a possible terminator as a literal and mark the block done
        case (phase_next)
          PH_Z0: begin
            lst        = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            phase_next = PH_IDLE;
          end
          PH_Z0E: begin
            lst        = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            phase_next = PH_ED1;
          end
          PH_Z0EE: begin
            lst        = push_rec(lst, ZERO_BYTE, 8'd1, 1'b0, 1'b0);
            phase_next = PH_ED2;
          end
          default: begin
          end
        endcase

        if (phase_next == PH_ED1) begin
          lst = push_rec(lst, RUN_MARK, 8'd1, 1'b1, 1'b0);
        end else if (phase_next == PH_ED2 || phase_next == PH_CNT) begin
          lst = push_rec(lst, 8'd0, 8'd0, 1'b1, 1'b1);
        end else if (lst.cnt == 2'd0) begin
          lst = push_rec(lst, 8'd0, 8'd0, 1'b1, 1'b0);
        end else begin
          lst.recs[lst.cnt - 2'd1].done = 1'b1;
        end
        phase_next          = PH_IDLE;
        block_finished_next = 1'b1;
      end
    end

    if (lst.cnt != 2'd0) begin
      lst.recs[lst.cnt - 2'd1].last = 1'b1;
    end
  end

  always_comb begin
    done_any = 1'b0;
    for (int i = 0; i < REC_SLOTS; i++) begin
      if (2'(i) < lst.cnt && lst.recs[i].done) begin
        done_any = 1'b1;
      end
    end
  end

  assign rec_cnt = lst.cnt;
  assign recs    = lst.recs;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      write_address  <= 16'd0;
      run_length     <= 8'd0;
      block_finished <= 1'b1;
    end else if (fire) begin
      phase          <= phase_next;
      write_address  <= lst.wa;
      run_length     <= run_length_next;
      block_finished <= block_finished_next;
    end
  end

  `ASSERT_CLK(a_no_open_block, clk, rst,
              fire && !start_block && block_finished |-> rec_cnt == 2'd0)
  `ASSERT_CLK(a_done_closes, clk, rst, fire && done_any |=> block_finished)

endmodule
